@@ sv/crev_pkg.sv @@
package crev_pkg;

  localparam int unsigned COMB_LEN_A_DEF     = 1310;
  localparam int unsigned COMB_LEN_B_DEF     = 1636;
  localparam int unsigned COMB_LEN_C_DEF     = 1813;
  localparam int unsigned COMB_LEN_D_DEF     = 1927;
  localparam int unsigned DIFFUSER_LEN_A_DEF = 221;
  localparam int unsigned DIFFUSER_LEN_B_DEF = 75;

  localparam int unsigned SAMPLE_W  = 24;
  localparam int unsigned CPOS_W    = 11;
  localparam int unsigned DPOS_W    = 8;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned WET_W     = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned STEP_W    = 4;
  localparam int unsigned MIX_W     = 28;

  localparam logic [CFG_IDX_W-1:0] CFG_ROOM_FEEDBACK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN      = 2'd2;

  localparam logic [COEF_W-1:0] ROOM_FEEDBACK_RST = 16'd55050;
  localparam logic [COEF_W-1:0] DAMPING_RST       = 16'd13107;
  localparam logic [WET_W-1:0]  WET_GAIN_RST      = 17'd21845;

  typedef logic [2:0] crev_line_t;

  localparam crev_line_t LINE_CA = 3'd0;
  localparam crev_line_t LINE_CB = 3'd1;
  localparam crev_line_t LINE_CC = 3'd2;
  localparam crev_line_t LINE_CD = 3'd3;
  localparam crev_line_t LINE_AA = 3'd4;
  localparam crev_line_t LINE_AB = 3'd5;

  typedef logic [STEP_W-1:0] crev_step_t;

  localparam crev_step_t STEP_RD_CA = 4'd0;
  localparam crev_step_t STEP_RD_CB = 4'd1;
  localparam crev_step_t STEP_RD_CC = 4'd2;
  localparam crev_step_t STEP_RD_CD = 4'd3;
  localparam crev_step_t STEP_RD_AA = 4'd7;
  localparam crev_step_t STEP_RD_AB = 4'd8;
  localparam crev_step_t STEP_WET   = 4'd10;
  localparam crev_step_t STEP_LAST  = 4'd11;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } crev_state_e;

  typedef struct packed {
    logic                       vld;
    logic [1:0]                 idx;
    logic signed [SAMPLE_W-1:0] y;
  } crev_comb_req_t;

  typedef struct packed {
    logic                       vld;
    logic [1:0]                 idx;
    logic signed [SAMPLE_W-1:0] data;
  } crev_line_wr_t;

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [47:0] v);
    logic all_ones;
    logic all_zero;
    all_ones = &v[47:SAMPLE_W-1];
    all_zero = ~|v[47:SAMPLE_W-1];
    if (all_ones || all_zero) begin
      return v[SAMPLE_W-1:0];
    end else if (v[47]) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

  // round half up, then drop 16 fraction bits
  function automatic logic signed [47:0] rnd16(input logic signed [47:0] v);
    logic signed [47:0] t;
    t = v + 48'sd32768;
    return t >>> 16;
  endfunction

endpackage

@@ sv/crev_line_mem.sv @@
module crev_line_mem #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [ADDR_W-1:0]             wr_addr_i,
  input  logic [crev_pkg::SAMPLE_W-1:0] wr_data_i,
  input  logic                          rd_en_i,
  input  logic [ADDR_W-1:0]             rd_addr_i,
  output logic [crev_pkg::SAMPLE_W-1:0] rd_data_o
);

  logic [crev_pkg::SAMPLE_W-1:0] mem_q [DEPTH];
  logic [crev_pkg::SAMPLE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/crev_comb_unit.sv @@
module crev_comb_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [crev_pkg::COEF_W-1:0]          room_feedback_i,
  input  logic [crev_pkg::COEF_W-1:0]          damping_i,
  input  logic signed [crev_pkg::SAMPLE_W-1:0] x_i,
  input  crev_pkg::crev_comb_req_t             req_i,
  output crev_pkg::crev_line_wr_t              wr_o
);

  logic signed [crev_pkg::SAMPLE_W-1:0] damp_q [4];

  logic signed [crev_pkg::SAMPLE_W:0]   diff;
  logic signed [41:0]                   prod1_d;
  logic signed [41:0]                   prod1_q;
  logic                                 s1_vld_q;
  logic [1:0]                           s1_idx_q;
  logic signed [crev_pkg::SAMPLE_W-1:0] s1_y_q;

  logic signed [crev_pkg::SAMPLE_W-1:0] s_new;
  logic                                 s2_vld_q;
  logic [1:0]                           s2_idx_q;
  logic signed [crev_pkg::SAMPLE_W-1:0] s2_s_q;

  logic signed [40:0]                   prod2_d;
  logic signed [40:0]                   prod2_q;
  logic                                 s3_vld_q;
  logic [1:0]                           s3_idx_q;

  // y*(1-d) + s*d folded into y + (s-y)*d
  assign diff    = (crev_pkg::SAMPLE_W+1)'(damp_q[req_i.idx])
                 - (crev_pkg::SAMPLE_W+1)'(req_i.y);
  assign prod1_d = diff * $signed({1'b0, damping_i});
  assign s_new   = crev_pkg::sat24(crev_pkg::rnd16((48'(s1_y_q) <<< 16) + 48'(prod1_q)));
  assign prod2_d = s2_s_q * $signed({1'b0, room_feedback_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        damp_q[k] <= '0;
      end
    end else begin
      s1_vld_q <= req_i.vld;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      if (s1_vld_q) begin
        damp_q[s1_idx_q] <= s_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= req_i.idx;
    s1_y_q   <= req_i.y;
    prod1_q  <= prod1_d;
    s2_idx_q <= s1_idx_q;
    s2_s_q   <= s_new;
    s3_idx_q <= s2_idx_q;
    prod2_q  <= prod2_d;
  end

  assign wr_o.vld  = s3_vld_q;
  assign wr_o.idx  = s3_idx_q;
  assign wr_o.data = crev_pkg::sat24(48'(x_i) + crev_pkg::rnd16(48'(prod2_q)));

  a_req_to_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.vld |-> ##3 wr_o.vld)
    else $error("comb request did not reach the write stage");

endmodule

@@ sv/crev_seq.sv @@
module crev_seq #(
  parameter int unsigned COMB_LEN_A     = crev_pkg::COMB_LEN_A_DEF,
  parameter int unsigned COMB_LEN_B     = crev_pkg::COMB_LEN_B_DEF,
  parameter int unsigned COMB_LEN_C     = crev_pkg::COMB_LEN_C_DEF,
  parameter int unsigned COMB_LEN_D     = crev_pkg::COMB_LEN_D_DEF,
  parameter int unsigned DIFFUSER_LEN_A = crev_pkg::DIFFUSER_LEN_A_DEF,
  parameter int unsigned DIFFUSER_LEN_B = crev_pkg::DIFFUSER_LEN_B_DEF,
  localparam int unsigned TOTAL_DEPTH = COMB_LEN_A + COMB_LEN_B + COMB_LEN_C + COMB_LEN_D
                                      + DIFFUSER_LEN_A + DIFFUSER_LEN_B,
  localparam int unsigned ADDR_W = $clog2(TOTAL_DEPTH)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [crev_pkg::SAMPLE_W-1:0] sample_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [crev_pkg::SAMPLE_W-1:0] sample_out_o,
  input  logic [crev_pkg::WET_W-1:0]           wet_gain_i,
  output logic signed [crev_pkg::SAMPLE_W-1:0] x_o,
  output crev_pkg::crev_comb_req_t             comb_req_o,
  input  crev_pkg::crev_line_wr_t              comb_wr_i,
  output logic                                 rd_en_o,
  output logic [ADDR_W-1:0]                    rd_addr_o,
  input  logic [crev_pkg::SAMPLE_W-1:0]        rd_data_i,
  output logic                                 wr_en_o,
  output logic [ADDR_W-1:0]                    wr_addr_o,
  output logic [crev_pkg::SAMPLE_W-1:0]        wr_data_o
);

  localparam int unsigned BASE_CB = COMB_LEN_A;
  localparam int unsigned BASE_CC = BASE_CB + COMB_LEN_B;
  localparam int unsigned BASE_CD = BASE_CC + COMB_LEN_C;
  localparam int unsigned BASE_AA = BASE_CD + COMB_LEN_D;
  localparam int unsigned BASE_AB = BASE_AA + DIFFUSER_LEN_A;
  localparam int unsigned COMB_LEN [4] = '{COMB_LEN_A, COMB_LEN_B, COMB_LEN_C, COMB_LEN_D};
  localparam int unsigned DIF_LEN [2]  = '{DIFFUSER_LEN_A, DIFFUSER_LEN_B};

  crev_pkg::crev_state_e state_q, state_d;
  crev_pkg::crev_step_t  cnt_q, cnt_d;
  logic                  finish;

  logic [crev_pkg::CPOS_W-1:0] comb_pos_q [4];
  logic [crev_pkg::DPOS_W-1:0] dif_pos_q [2];
  logic [5:0]                  filled_q;
  logic [ADDR_W-1:0]           line_addr [6];

  logic                 rd_en;
  crev_pkg::crev_line_t rd_line;
  logic                 rd_vld_q;
  crev_pkg::crev_line_t rd_line_q;

  logic signed [crev_pkg::SAMPLE_W-1:0] x_q;
  logic signed [crev_pkg::SAMPLE_W-1:0] y_rd;
  logic signed [crev_pkg::MIX_W-1:0]    w_q;
  logic signed [crev_pkg::SAMPLE_W-1:0] ap_data;
  logic                                 ap_wr;
  logic signed [45:0]                   prod3_d;
  logic signed [45:0]                   prod3_q;
  logic                                 out_valid_q;
  logic signed [crev_pkg::SAMPLE_W-1:0] sample_out_q;

  assign line_addr[0] = ADDR_W'(comb_pos_q[0]);
  assign line_addr[1] = ADDR_W'(BASE_CB) + ADDR_W'(comb_pos_q[1]);
  assign line_addr[2] = ADDR_W'(BASE_CC) + ADDR_W'(comb_pos_q[2]);
  assign line_addr[3] = ADDR_W'(BASE_CD) + ADDR_W'(comb_pos_q[3]);
  assign line_addr[4] = ADDR_W'(BASE_AA) + ADDR_W'(dif_pos_q[0]);
  assign line_addr[5] = ADDR_W'(BASE_AB) + ADDR_W'(dif_pos_q[1]);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    finish     = 1'b0;
    unique case (state_q)
      crev_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = crev_pkg::ST_RUN;
          cnt_d   = crev_pkg::STEP_RD_CA;
        end
      end
      crev_pkg::ST_RUN: begin
        if (cnt_q == crev_pkg::STEP_LAST) begin
          if (!out_valid_q || out_ready_i) begin
            finish  = 1'b1;
            state_d = crev_pkg::ST_IDLE;
          end
        end else begin
          cnt_d = cnt_q + crev_pkg::crev_step_t'(1);
        end
      end
      default: begin
        state_d = crev_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crev_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // read schedule: four combs back to back, allpass lines once w is complete
  always_comb begin
    rd_en   = 1'b0;
    rd_line = crev_pkg::LINE_CA;
    if (state_q == crev_pkg::ST_RUN) begin
      unique case (cnt_q)
        crev_pkg::STEP_RD_CA: begin
          rd_en   = 1'b1;
          rd_line = crev_pkg::LINE_CA;
        end
        crev_pkg::STEP_RD_CB: begin
          rd_en   = 1'b1;
          rd_line = crev_pkg::LINE_CB;
        end
        crev_pkg::STEP_RD_CC: begin
          rd_en   = 1'b1;
          rd_line = crev_pkg::LINE_CC;
        end
        crev_pkg::STEP_RD_CD: begin
          rd_en   = 1'b1;
          rd_line = crev_pkg::LINE_CD;
        end
        crev_pkg::STEP_RD_AA: begin
          rd_en   = 1'b1;
          rd_line = crev_pkg::LINE_AA;
        end
        crev_pkg::STEP_RD_AB: begin
          rd_en   = 1'b1;
          rd_line = crev_pkg::LINE_AB;
        end
        default: begin
          rd_en = 1'b0;
        end
      endcase
    end
  end

  assign rd_en_o   = rd_en;
  assign rd_addr_o = line_addr[rd_line];

  // entries of a line that has not wrapped yet are read as zero
  assign y_rd = filled_q[rd_line_q] ? $signed(rd_data_i) : '0;

  assign comb_req_o.vld = rd_vld_q && (rd_line_q <= crev_pkg::LINE_CD);
  assign comb_req_o.idx = rd_line_q[1:0];
  assign comb_req_o.y   = y_rd;

  assign ap_wr   = rd_vld_q && (rd_line_q == crev_pkg::LINE_AA ||
                                rd_line_q == crev_pkg::LINE_AB);
  assign ap_data = crev_pkg::sat24(48'(w_q) + 48'(y_rd >>> 1));

  assign wr_en_o   = comb_wr_i.vld || ap_wr;
  assign wr_addr_o = ap_wr ? line_addr[rd_line_q] : line_addr[{1'b0, comb_wr_i.idx}];
  assign wr_data_o = ap_wr ? ap_data : comb_wr_i.data;

  assign prod3_d = w_q * $signed({1'b0, wet_gain_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      rd_line_q   <= crev_pkg::LINE_CA;
      out_valid_q <= 1'b0;
      filled_q    <= '0;
      for (int k = 0; k < 4; k++) begin
        comb_pos_q[k] <= '0;
      end
      for (int k = 0; k < 2; k++) begin
        dif_pos_q[k] <= '0;
      end
    end else begin
      rd_vld_q  <= rd_en;
      rd_line_q <= rd_line;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (finish) begin
        for (int k = 0; k < 4; k++) begin
          if (comb_pos_q[k] == crev_pkg::CPOS_W'(COMB_LEN[k] - 1)) begin
            comb_pos_q[k] <= '0;
            filled_q[k]   <= 1'b1;
          end else begin
            comb_pos_q[k] <= comb_pos_q[k] + crev_pkg::CPOS_W'(1);
          end
        end
        for (int k = 0; k < 2; k++) begin
          if (dif_pos_q[k] == crev_pkg::DPOS_W'(DIF_LEN[k] - 1)) begin
            dif_pos_q[k]    <= '0;
            filled_q[4 + k] <= 1'b1;
          end else begin
            dif_pos_q[k] <= dif_pos_q[k] + crev_pkg::DPOS_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      x_q <= sample_in_i;
    end
    if (rd_vld_q) begin
      priority if (rd_line_q == crev_pkg::LINE_CA) begin
        w_q <= crev_pkg::MIX_W'(y_rd);
      end else if (rd_line_q <= crev_pkg::LINE_CD) begin
        w_q <= w_q + crev_pkg::MIX_W'(y_rd);
      end else begin
        w_q <= crev_pkg::MIX_W'(y_rd) - w_q;
      end
    end
    if (state_q == crev_pkg::ST_RUN && cnt_q == crev_pkg::STEP_WET) begin
      prod3_q <= prod3_d;
    end
    if (finish) begin
      sample_out_q <= crev_pkg::sat24(48'(x_q) + crev_pkg::rnd16(48'(prod3_q)));
    end
  end

  assign x_o          = x_q;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;

  a_one_writer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    comb_wr_i.vld |-> !ap_wr)
    else $error("comb and allpass write in the same cycle");

  a_hold_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == crev_pkg::ST_RUN && cnt_q == crev_pkg::STEP_LAST &&
     out_valid_q && !out_ready_i)
    |=> (state_q == crev_pkg::ST_RUN && cnt_q == crev_pkg::STEP_LAST))
    else $error("result left the last step while output was blocked");

  a_finish_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_q)
    else $error("finished request not presented");

endmodule

@@ sv/comb_allpass_reverb.sv @@
// channel   | handshake                  | payload
// ----------+----------------------------+--------------------------------
// input     | in_valid_i / in_ready_o    | sample_in_i
// output    | out_valid_o / out_ready_i  | sample_out_o
// config    | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// a request is taken while idle and no new one is taken until it finishes; its
// steps are scheduled around the single read and write port of the line memory
// (4 comb reads, 4 comb write-backs after the damping pipeline, 2 allpass steps)
// reset needs no clearing pass: a delay line reads as zero until its first wrap
// when a finished result is still waiting, the request holds at its last step

module comb_allpass_reverb #(
  parameter int unsigned COMB_LEN_A     = crev_pkg::COMB_LEN_A_DEF,
  parameter int unsigned COMB_LEN_B     = crev_pkg::COMB_LEN_B_DEF,
  parameter int unsigned COMB_LEN_C     = crev_pkg::COMB_LEN_C_DEF,
  parameter int unsigned COMB_LEN_D     = crev_pkg::COMB_LEN_D_DEF,
  parameter int unsigned DIFFUSER_LEN_A = crev_pkg::DIFFUSER_LEN_A_DEF,
  parameter int unsigned DIFFUSER_LEN_B = crev_pkg::DIFFUSER_LEN_B_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [crev_pkg::SAMPLE_W-1:0] sample_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [crev_pkg::SAMPLE_W-1:0] sample_out_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [crev_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [crev_pkg::WET_W-1:0]           cfg_data_i
);

  localparam int unsigned TOTAL_DEPTH = COMB_LEN_A + COMB_LEN_B + COMB_LEN_C + COMB_LEN_D
                                      + DIFFUSER_LEN_A + DIFFUSER_LEN_B;
  localparam int unsigned ADDR_W = $clog2(TOTAL_DEPTH);

  logic [crev_pkg::COEF_W-1:0] room_feedback_q;
  logic [crev_pkg::COEF_W-1:0] damping_q;
  logic [crev_pkg::WET_W-1:0]  wet_gain_q;

  logic                                 rd_en;
  logic [ADDR_W-1:0]                    rd_addr;
  logic [crev_pkg::SAMPLE_W-1:0]        rd_data;
  logic                                 wr_en;
  logic [ADDR_W-1:0]                    wr_addr;
  logic [crev_pkg::SAMPLE_W-1:0]        wr_data;
  logic signed [crev_pkg::SAMPLE_W-1:0] x;
  crev_pkg::crev_comb_req_t             comb_req;
  crev_pkg::crev_line_wr_t              comb_wr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_feedback_q <= crev_pkg::ROOM_FEEDBACK_RST;
      damping_q       <= crev_pkg::DAMPING_RST;
      wet_gain_q      <= crev_pkg::WET_GAIN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        crev_pkg::CFG_ROOM_FEEDBACK: room_feedback_q <= cfg_data_i[crev_pkg::COEF_W-1:0];
        crev_pkg::CFG_DAMPING:       damping_q       <= cfg_data_i[crev_pkg::COEF_W-1:0];
        crev_pkg::CFG_WET_GAIN:      wet_gain_q      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  crev_line_mem #(
    .DEPTH (TOTAL_DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  crev_comb_unit u_comb (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .room_feedback_i (room_feedback_q),
    .damping_i       (damping_q),
    .x_i             (x),
    .req_i           (comb_req),
    .wr_o            (comb_wr)
  );

  crev_seq #(
    .COMB_LEN_A     (COMB_LEN_A),
    .COMB_LEN_B     (COMB_LEN_B),
    .COMB_LEN_C     (COMB_LEN_C),
    .COMB_LEN_D     (COMB_LEN_D),
    .DIFFUSER_LEN_A (DIFFUSER_LEN_A),
    .DIFFUSER_LEN_B (DIFFUSER_LEN_B)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .wet_gain_i   (wet_gain_q),
    .x_o          (x),
    .comb_req_o   (comb_req),
    .comb_wr_i    (comb_wr),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [crev_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int MAX_REPORTS = 10;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni;
  logic                                 in_valid_i;
  logic                                 in_ready_o;
  logic signed [crev_pkg::SAMPLE_W-1:0] sample_in_i;
  logic                                 out_valid_o;
  logic                                 out_ready_i = 1'b0;
  logic signed [crev_pkg::SAMPLE_W-1:0] sample_out_o;
  logic                                 cfg_valid_i;
  logic                                 cfg_ready_o;
  logic [crev_pkg::CFG_IDX_W-1:0]       cfg_index_i;
  logic [crev_pkg::WET_W-1:0]           cfg_data_i;

  comb_allpass_reverb dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // reverb state mirrored on the testbench side
  longint comb_mem [4][2048];
  longint diff_mem [2][256];
  int     comb_len [4];
  int     diff_len [2];
  int     comb_pos [4];
  int     diff_pos [2];
  longint damp_st  [4];
  int     room_fb;
  int     damp_w;
  int     wet_g;

  logic signed [crev_pkg::SAMPLE_W-1:0] mix_q [$];
  int  fail_cnt;
  bit  src_idle;
  bit  sink_idle;
  bit  out_hold;
  int  hold_len;
  int  sink_stall = 0;
  event hold_go;

  function automatic longint clip24(input longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint round_q16(input longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  task automatic clear_reverb();
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 2048; i++) comb_mem[k][i] = 0;
      comb_pos[k] = 0;
      damp_st[k]  = 0;
    end
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 256; i++) diff_mem[k][i] = 0;
      diff_pos[k] = 0;
    end
    comb_len[0] = int'(crev_pkg::COMB_LEN_A_DEF);
    comb_len[1] = int'(crev_pkg::COMB_LEN_B_DEF);
    comb_len[2] = int'(crev_pkg::COMB_LEN_C_DEF);
    comb_len[3] = int'(crev_pkg::COMB_LEN_D_DEF);
    diff_len[0] = int'(crev_pkg::DIFFUSER_LEN_A_DEF);
    diff_len[1] = int'(crev_pkg::DIFFUSER_LEN_B_DEF);
    room_fb = int'(crev_pkg::ROOM_FEEDBACK_RST);
    damp_w  = int'(crev_pkg::DAMPING_RST);
    wet_g   = int'(crev_pkg::WET_GAIN_RST);
  endtask

  function automatic logic signed [crev_pkg::SAMPLE_W-1:0] reverb_mix(
    input logic signed [crev_pkg::SAMPLE_W-1:0] dry
  );
    longint x;
    longint w;
    longint y;
    longint s;
    longint z;
    int     p;
    x = longint'(dry);
    w = 0;
    for (int k = 0; k < 4; k++) begin
      p = comb_pos[k];
      if (p >= comb_len[k]) p = 0;
      y = comb_mem[k][p];
      s = clip24(round_q16(y * (65536 - damp_w) + damp_st[k] * damp_w));
      damp_st[k] = s;
      comb_mem[k][p] = clip24(x + round_q16(s * room_fb));
      p++;
      if (p >= comb_len[k]) p = 0;
      comb_pos[k] = p;
      w += y;
    end
    for (int k = 0; k < 2; k++) begin
      p = diff_pos[k];
      if (p >= diff_len[k]) p = 0;
      z = diff_mem[k][p];
      diff_mem[k][p] = clip24(w + (z >>> 1));
      p++;
      if (p >= diff_len[k]) p = 0;
      diff_pos[k] = p;
      w = z - w;
    end
    return crev_pkg::SAMPLE_W'(clip24(x + round_q16(w * wet_g)));
  endfunction

  function automatic logic signed [crev_pkg::SAMPLE_W-1:0] pick_sample();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return crev_pkg::SAMPLE_W'($urandom());
    if (sel < 8) return crev_pkg::SAMPLE_W'(int'($urandom_range(0, 8191)) - 4096);
    if (sel == 8) return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
    return '0;
  endfunction

  // output side
  always @(negedge clk_i) begin
    if (out_hold) begin
      out_ready_i <= 1'b0;
    end else if (sink_stall > 0) begin
      out_ready_i <= 1'b0;
      sink_stall--;
    end else if (sink_idle && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      sink_stall = $urandom_range(0, 3);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    out_hold = 1'b0;
    forever begin
      @(hold_go);
      @(posedge clk_i);
      out_hold = 1'b1;
      repeat (hold_len) @(posedge clk_i);
      out_hold = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    logic signed [crev_pkg::SAMPLE_W-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (mix_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("unexpected sample_out %0d with no request pending", sample_out_o);
      end else begin
        want = mix_q.pop_front();
        if (sample_out_o !== want) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("mismatch sample_out: expected %0d got %0d", want, sample_out_o);
        end
      end
    end
  end

  // input side
  task automatic send_sample(input logic signed [crev_pkg::SAMPLE_W-1:0] x);
    int gap;
    gap = 0;
    if (src_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= x;
    do @(posedge clk_i); while (!in_ready_o);
    mix_q.push_back(reverb_mix(x));
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (mix_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [crev_pkg::CFG_IDX_W-1:0] idx,
                           input logic [crev_pkg::WET_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      crev_pkg::CFG_ROOM_FEEDBACK: room_fb = int'(val[crev_pkg::COEF_W-1:0]);
      crev_pkg::CFG_DAMPING:       damp_w  = int'(val[crev_pkg::COEF_W-1:0]);
      crev_pkg::CFG_WET_GAIN:      wet_g   = int'(val);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(input int room, input int damp, input int wet);
    write_reg(crev_pkg::CFG_ROOM_FEEDBACK, crev_pkg::WET_W'(room));
    write_reg(crev_pkg::CFG_DAMPING, crev_pkg::WET_W'(damp));
    write_reg(crev_pkg::CFG_WET_GAIN, crev_pkg::WET_W'(wet));
  endtask

  // tests
  task automatic test_reset_settings();
    send_sample('0);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample(24'sh000001);
    send_sample(24'shFFFFFF);
    send_sample(24'sh555555);
    send_sample(24'shAAAAAA);
    settle();
  endtask

  task automatic test_register_extremes();
    set_regs(65535, 0, 131071);
    repeat (6) send_sample(24'sh7FFFFF);
    repeat (6) send_sample(24'sh800000);
    settle();
    // index past the register list is dropped
    write_reg(CFG_UNUSED, '1);
    send_sample(24'sh400000);
    send_sample(24'shC00000);
    settle();
    set_regs(0, 65535, 0);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    settle();
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: set_regs(65535, 0, 131071);
        2: set_regs(0, 65535, 65536);
        3: set_regs(int'($urandom_range(60000, 65535)), int'($urandom_range(0, 8000)),
                    int'($urandom_range(65536, 131071)));
        default: begin
          write_reg(crev_pkg::CFG_ROOM_FEEDBACK, crev_pkg::WET_W'($urandom()));
          write_reg(crev_pkg::CFG_DAMPING, crev_pkg::WET_W'($urandom()));
          write_reg(crev_pkg::CFG_WET_GAIN, crev_pkg::WET_W'($urandom()));
        end
      endcase
      repeat (260) send_sample(pick_sample());
      settle();
    end
  endtask

  task automatic test_output_backpressure();
    src_idle = 1'b0;
    hold_len = 400;
    -> hold_go;
    repeat (30) send_sample(pick_sample());
    settle();
    src_idle = 1'b1;
  endtask

  task automatic test_full_rate();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    set_regs(55050, 13107, 21845);
    repeat (340) send_sample(pick_sample());
    settle();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sample_in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    fail_cnt    = 0;
    hold_len    = 0;
    src_idle    = 1'b1;
    sink_idle   = 1'b1;
    clear_reverb();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_settings();
    test_register_extremes();
    test_random_settings();
    test_output_backpressure();
    test_full_rate();

    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0 && mix_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
